/* design/ptc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and helpers of the pressure/temperature compensation
// block.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned CAL_W       = 16;
  localparam int unsigned RAW_W       = 24;
  localparam int unsigned DT_W        = 25;
  localparam int unsigned TEMP_W      = 19;
  localparam int unsigned PRES_W      = 24;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned PTC_QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEFF       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_COEFF     = 3'd5;

  localparam logic signed [18:0] TEMP_BASE   = 19'sd2000;
  localparam logic signed [19:0] VLOW_SHIFT  = 20'sd3500;
  localparam logic signed [18:0] VLOW_LIMIT  = -19'sd3500;
  localparam logic signed [19:0] TEMP_MIN    = -20'sd262144;
  localparam logic signed [19:0] TEMP_MAX    = 20'sd262143;
  localparam logic signed [63:0] PRES_MIN    = -64'sd8388608;
  localparam logic signed [63:0] PRES_MAX    = 64'sd8388607;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sens_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_coeff;
  } ptc_cal_t;

  typedef struct packed {
    logic        [RAW_W-1:0] d1;
    logic signed [DT_W-1:0]  dt;
  } ptc_item_t;

  // arithmetic right shift that rounds toward zero
  function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] x,
                                                    input int unsigned sh);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (x + bias) >>> sh;
  endfunction

endpackage
`default_nettype wire

/* design/ptc_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_if
// Valid/ready channels for raw reading pairs and compensated results.
// ----------------------------------------------------------------------------
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_pressure;
  logic [23:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] temperature;
  logic signed [23:0] pressure;

  modport source (output valid, output temperature, output pressure, input ready);
  modport sink   (input valid, input temperature, input pressure, output ready);
endinterface
`default_nettype wire

/* design/pressure_temp_compensation.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Second-order compensation of raw pressure and temperature readings.
// ----------------------------------------------------------------------------
// One pair of raw readings is taken per cycle while the queue has room and one
// result (temperature in hundredths of a degree, pressure in hundredths of a
// millibar, both saturated) leaves per cycle unless the output stalls; each
// passes the input register, the queue, the nine-stage pipeline, whose
// longest step is the split 24 by 42 bit pressure product, and the output
// register. A stalled result freezes the pipeline only; the queue keeps taking
// transactions until it fills. Write the calibration words only while idle.
// ----------------------------------------------------------------------------
module pressure_temp_compensation #(
  parameter int unsigned QUEUE_DEPTH = ptc_pkg::PTC_QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ptc_in_if.sink                             in_chan,
  ptc_out_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ptc_pkg::CAL_W-1:0]     cfg_wdata
);

  ptc_pkg::ptc_cal_t  cal_r, cal_nxt;
  logic               push_valid, push_ready;
  ptc_pkg::ptc_item_t push_item;
  logic               pop_valid, pop_ready;
  ptc_pkg::ptc_item_t pop_item;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ptc_pkg::REG_PRESSURE_SENSITIVITY:  cal_nxt.pressure_sensitivity  = cfg_wdata;
        ptc_pkg::REG_PRESSURE_OFFSET:       cal_nxt.pressure_offset       = cfg_wdata;
        ptc_pkg::REG_SENS_TEMP_COEFF:       cal_nxt.sens_temp_coeff       = cfg_wdata;
        ptc_pkg::REG_OFFSET_TEMP_COEFF:     cal_nxt.offset_temp_coeff     = cfg_wdata;
        ptc_pkg::REG_REFERENCE_TEMPERATURE: cal_nxt.reference_temperature = cfg_wdata;
        ptc_pkg::REG_TEMPERATURE_COEFF:     cal_nxt.temperature_coeff     = cfg_wdata;
        default: cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  ptc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cal        (cal_r),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  ptc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  ptc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cal      (cal_r),
    .q_valid  (pop_valid),
    .q_item   (pop_item),
    .q_ready  (pop_ready),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

/* design/ptc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_front
// Input stage: accepts reading pairs and forms the temperature difference.
// ----------------------------------------------------------------------------
module ptc_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ptc_pkg::ptc_cal_t   cal,
  ptc_in_if.sink                   in_chan,
  output logic                     push_valid,
  output ptc_pkg::ptc_item_t       push_item,
  input  wire logic                push_ready
);

  logic               valid_r;
  logic               valid_nxt;
  ptc_pkg::ptc_item_t item_r;
  ptc_pkg::ptc_item_t item_nxt;
  logic               take;

  assign in_chan.ready = !valid_r || push_ready;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    item_nxt.d1 = in_chan.raw_pressure;
    item_nxt.dt = $signed({1'b0, in_chan.raw_temperature})
                - $signed({1'b0, cal.reference_temperature, 8'h00});
    valid_nxt   = take || (valid_r && !push_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule
`default_nettype wire

/* design/ptc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_queue
// Short FIFO between the input stage and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module ptc_queue #(
  parameter int unsigned DEPTH = ptc_pkg::PTC_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  input  wire ptc_pkg::ptc_item_t push_item,
  output logic                    push_ready,
  output logic                    pop_valid,
  output ptc_pkg::ptc_item_t      pop_item,
  input  wire logic               pop_ready
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  ptc_pkg::ptc_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* design/ptc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_back
// Arithmetic pipeline: first- and second-order correction, pressure product,
// saturation and the output register.
// ----------------------------------------------------------------------------
module ptc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ptc_pkg::ptc_cal_t  cal,
  input  wire logic               q_valid,
  input  wire ptc_pkg::ptc_item_t q_item,
  output logic                    q_ready,
  ptc_out_if.source               out_chan
);

  localparam int unsigned NSTG = 9;

  logic            adv;
  logic            pop;
  logic [NSTG-1:0] v_r, v_nxt;
  logic            out_valid_r, out_valid_nxt;

  // stage 1: products of the temperature difference
  logic        [23:0] s1_d1_r,  s1_d1_nxt;
  logic signed [41:0] s1_mt_r,  s1_mt_nxt;
  logic signed [41:0] s1_mo_r,  s1_mo_nxt;
  logic signed [41:0] s1_ms_r,  s1_ms_nxt;
  logic signed [49:0] s1_mdd_r, s1_mdd_nxt;
  // stage 2: first-order terms
  logic        [23:0] s2_d1_r,   s2_d1_nxt;
  logic signed [18:0] s2_a_r,    s2_a_nxt;
  logic signed [18:0] s2_t1_r,   s2_t1_nxt;
  logic signed [39:0] s2_off_r,  s2_off_nxt;
  logic signed [39:0] s2_sens_r, s2_sens_nxt;
  logic        [17:0] s2_t2_r,   s2_t2_nxt;
  // stage 3: squares and corrected temperature
  logic        [23:0] s3_d1_r,   s3_d1_nxt;
  logic               s3_low_r,  s3_low_nxt;
  logic               s3_vlow_r, s3_vlow_nxt;
  logic        [36:0] s3_sq_r,   s3_sq_nxt;
  logic        [37:0] s3_bsq_r,  s3_bsq_nxt;
  logic signed [19:0] s3_temp_r, s3_temp_nxt;
  logic signed [39:0] s3_off_r,  s3_off_nxt;
  logic signed [39:0] s3_sens_r, s3_sens_nxt;
  // stage 4: second-order corrections
  logic        [23:0] s4_d1_r,    s4_d1_nxt;
  logic        [35:0] s4_off2_r,  s4_off2_nxt;
  logic        [40:0] s4_sens2_r, s4_sens2_nxt;
  logic signed [19:0] s4_temp_r,  s4_temp_nxt;
  logic signed [39:0] s4_off_r,   s4_off_nxt;
  logic signed [39:0] s4_sens_r,  s4_sens_nxt;
  // stage 5: final offset and sensitivity
  logic        [23:0] s5_d1_r,   s5_d1_nxt;
  logic signed [19:0] s5_temp_r, s5_temp_nxt;
  logic signed [41:0] s5_off_r,  s5_off_nxt;
  logic signed [41:0] s5_sens_r, s5_sens_nxt;
  // stage 6: partial products of the pressure term
  logic        [44:0] s6_pl_r,   s6_pl_nxt;
  logic signed [45:0] s6_ph_r,   s6_ph_nxt;
  logic signed [19:0] s6_temp_r, s6_temp_nxt;
  logic signed [41:0] s6_off_r,  s6_off_nxt;
  // stage 7: full product
  logic signed [63:0] s7_prod_r, s7_prod_nxt;
  logic signed [19:0] s7_temp_r, s7_temp_nxt;
  logic signed [41:0] s7_off_r,  s7_off_nxt;
  // stage 8: scaled product
  logic signed [42:0] s8_pd_r,   s8_pd_nxt;
  logic signed [19:0] s8_temp_r, s8_temp_nxt;
  logic signed [41:0] s8_off_r,  s8_off_nxt;
  // stage 9: offset removed
  logic signed [44:0] s9_x_r,    s9_x_nxt;
  logic signed [19:0] s9_temp_r, s9_temp_nxt;
  // output register
  logic signed [18:0] temperature_r, temperature_nxt;
  logic signed [23:0] pressure_r,    pressure_nxt;

  logic signed [63:0] p_full;
  logic signed [19:0] b_val;
  logic        [37:0] sq_w;
  logic        [38:0] off2_w;
  logic        [40:0] sens2_w;

  assign adv     = !out_valid_r || out_chan.ready;
  assign q_ready = adv;
  assign pop     = adv && q_valid;

  always_comb begin
    v_nxt         = {v_r[NSTG-2:0], pop};
    out_valid_nxt = v_r[NSTG-1];

    s1_d1_nxt  = q_item.d1;
    s1_mt_nxt  = q_item.dt * $signed({1'b0, cal.temperature_coeff});
    s1_mo_nxt  = q_item.dt * $signed({1'b0, cal.offset_temp_coeff});
    s1_ms_nxt  = q_item.dt * $signed({1'b0, cal.sens_temp_coeff});
    s1_mdd_nxt = q_item.dt * q_item.dt;

    s2_d1_nxt   = s1_d1_r;
    s2_a_nxt    = 19'(ptc_pkg::trunc_shift(64'(s1_mt_r), 23));
    s2_t1_nxt   = s2_a_nxt + ptc_pkg::TEMP_BASE;
    s2_off_nxt  = $signed({6'b0, cal.pressure_offset, 18'b0})
                + 40'(ptc_pkg::trunc_shift(64'(s1_mo_r), 5));
    s2_sens_nxt = $signed({7'b0, cal.pressure_sensitivity, 17'b0})
                + 40'(ptc_pkg::trunc_shift(64'(s1_ms_r), 7));
    s2_t2_nxt   = 18'(((52'(unsigned'(s1_mdd_r)) << 1) + 52'(unsigned'(s1_mdd_r))) >> 33);

    s3_d1_nxt   = s2_d1_r;
    s3_low_nxt  = s2_a_r[18];
    s3_vlow_nxt = (s2_a_r < ptc_pkg::VLOW_LIMIT);
    sq_w        = unsigned'(38'(s2_a_r) * 38'(s2_a_r));
    s3_sq_nxt   = sq_w[36:0];
    b_val       = 20'(s2_a_r) + ptc_pkg::VLOW_SHIFT;
    s3_bsq_nxt  = unsigned'(38'(b_val) * 38'(b_val));
    s3_temp_nxt = 20'(s2_t1_r) - (s3_low_nxt ? $signed({2'b0, s2_t2_r}) : 20'sd0);
    s3_off_nxt  = s2_off_r;
    s3_sens_nxt = s2_sens_r;

    s4_d1_nxt    = s3_d1_r;
    off2_w       = (39'(s3_sq_r) << 1) + 39'(s3_sq_r);
    s4_off2_nxt  = s3_low_r ? 36'(off2_w >> 4) : '0;
    sens2_w      = (41'(s3_sq_r) << 3) - 41'(s3_sq_r)
                 + (s3_vlow_r ? (41'(s3_bsq_r) << 1) + 41'(s3_bsq_r) : '0);
    s4_sens2_nxt = s3_low_r ? sens2_w : '0;
    s4_temp_nxt  = s3_temp_r;
    s4_off_nxt   = s3_off_r;
    s4_sens_nxt  = s3_sens_r;

    s5_d1_nxt   = s4_d1_r;
    s5_temp_nxt = s4_temp_r;
    s5_off_nxt  = 42'(s4_off_r) - $signed({6'b0, s4_off2_r});
    s5_sens_nxt = 42'(s4_sens_r) - $signed({1'b0, s4_sens2_r});

    s6_pl_nxt   = 45'(s5_d1_r) * 45'(s5_sens_r[20:0]);
    s6_ph_nxt   = $signed({1'b0, s5_d1_r}) * $signed(s5_sens_r[41:21]);
    s6_temp_nxt = s5_temp_r;
    s6_off_nxt  = s5_off_r;

    s7_prod_nxt = (64'(s6_ph_r) <<< 21) + $signed(64'(s6_pl_r));
    s7_temp_nxt = s6_temp_r;
    s7_off_nxt  = s6_off_r;

    s8_pd_nxt   = 43'(ptc_pkg::trunc_shift(s7_prod_r, 21));
    s8_temp_nxt = s7_temp_r;
    s8_off_nxt  = s7_off_r;

    s9_x_nxt    = 45'(s8_pd_r) - 45'(s8_off_r);
    s9_temp_nxt = s8_temp_r;

    p_full = ptc_pkg::trunc_shift(64'(s9_x_r), 15);
    priority if (p_full < ptc_pkg::PRES_MIN) begin
      pressure_nxt = 24'(ptc_pkg::PRES_MIN);
    end else if (p_full > ptc_pkg::PRES_MAX) begin
      pressure_nxt = 24'(ptc_pkg::PRES_MAX);
    end else begin
      pressure_nxt = 24'(p_full);
    end
    priority if (s9_temp_r < ptc_pkg::TEMP_MIN) begin
      temperature_nxt = 19'(ptc_pkg::TEMP_MIN);
    end else if (s9_temp_r > ptc_pkg::TEMP_MAX) begin
      temperature_nxt = 19'(ptc_pkg::TEMP_MAX);
    end else begin
      temperature_nxt = 19'(s9_temp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d1_r    <= s1_d1_nxt;
      s1_mt_r    <= s1_mt_nxt;
      s1_mo_r    <= s1_mo_nxt;
      s1_ms_r    <= s1_ms_nxt;
      s1_mdd_r   <= s1_mdd_nxt;
      s2_d1_r    <= s2_d1_nxt;
      s2_a_r     <= s2_a_nxt;
      s2_t1_r    <= s2_t1_nxt;
      s2_off_r   <= s2_off_nxt;
      s2_sens_r  <= s2_sens_nxt;
      s2_t2_r    <= s2_t2_nxt;
      s3_d1_r    <= s3_d1_nxt;
      s3_low_r   <= s3_low_nxt;
      s3_vlow_r  <= s3_vlow_nxt;
      s3_sq_r    <= s3_sq_nxt;
      s3_bsq_r   <= s3_bsq_nxt;
      s3_temp_r  <= s3_temp_nxt;
      s3_off_r   <= s3_off_nxt;
      s3_sens_r  <= s3_sens_nxt;
      s4_d1_r    <= s4_d1_nxt;
      s4_off2_r  <= s4_off2_nxt;
      s4_sens2_r <= s4_sens2_nxt;
      s4_temp_r  <= s4_temp_nxt;
      s4_off_r   <= s4_off_nxt;
      s4_sens_r  <= s4_sens_nxt;
      s5_d1_r    <= s5_d1_nxt;
      s5_temp_r  <= s5_temp_nxt;
      s5_off_r   <= s5_off_nxt;
      s5_sens_r  <= s5_sens_nxt;
      s6_pl_r    <= s6_pl_nxt;
      s6_ph_r    <= s6_ph_nxt;
      s6_temp_r  <= s6_temp_nxt;
      s6_off_r   <= s6_off_nxt;
      s7_prod_r  <= s7_prod_nxt;
      s7_temp_r  <= s7_temp_nxt;
      s7_off_r   <= s7_off_nxt;
      s8_pd_r    <= s8_pd_nxt;
      s8_temp_r  <= s8_temp_nxt;
      s8_off_r   <= s8_off_nxt;
      s9_x_r     <= s9_x_nxt;
      s9_temp_r  <= s9_temp_nxt;
      temperature_r <= temperature_nxt;
      pressure_r    <= pressure_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.temperature = temperature_r;
  assign out_chan.pressure    = pressure_r;

endmodule
`default_nettype wire

/* tb/sv/ptc_compensation_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_compensation_checker
// Watches the reading and result channels and the calibration write port of
// the compensation block. For every accepted reading pair it computes the
// compensated temperature and pressure from its own copy of the calibration
// words, then compares each accepted result, field by field, with the oldest
// prediction still waiting. It hands a failure count and the number of
// predictions still waiting to the testbench top.
// ----------------------------------------------------------------------------
module ptc_compensation_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ptc_in_if                                  in_mon,
  ptc_out_if                                 out_mon,
  input  wire logic                          cfg_we,
  input  wire logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ptc_pkg::CAL_W-1:0]     cfg_wdata,
  output int                                 fail_count,
  output int                                 pending
);

  typedef struct packed {
    logic signed [ptc_pkg::TEMP_W-1:0] temperature;
    logic signed [ptc_pkg::PRES_W-1:0] pressure;
  } comp_result_t;

  ptc_pkg::ptc_cal_t cal_words;
  comp_result_t      predicted_results[$];

  function automatic comp_result_t compensate(input logic [ptc_pkg::RAW_W-1:0] raw_p,
                                              input logic [ptc_pkg::RAW_W-1:0] raw_t,
                                              input ptc_pkg::ptc_cal_t c);
    longint d1, d2, c_sens, c_off, c_tcs, c_tco, c_tref, c_tsens;
    longint dt, temp, off, sens, dev, sq, cold, p;
    comp_result_t res;
    d1      = longint'(raw_p);
    d2      = longint'(raw_t);
    c_sens  = longint'(c.pressure_sensitivity);
    c_off   = longint'(c.pressure_offset);
    c_tcs   = longint'(c.sens_temp_coeff);
    c_tco   = longint'(c.offset_temp_coeff);
    c_tref  = longint'(c.reference_temperature);
    c_tsens = longint'(c.temperature_coeff);

    dt   = d2 - c_tref * 256;
    temp = 2000 + (dt * c_tsens) / 8388608;
    off  = c_off * 262144 + (c_tco * dt) / 32;
    sens = c_sens * 131072 + (c_tcs * dt) / 128;

    // second-order correction below 20 C, extra sensitivity term below -15 C
    if (temp < 2000) begin
      dev  = temp - 2000;
      sq   = dev * dev;
      off  = off - (3 * sq) / 16;
      sens = sens - 7 * sq;
      if (temp < -1500) begin
        cold = temp + 1500;
        sens = sens - 3 * (cold * cold);
      end
      temp = temp - (3 * (dt * dt)) / 64'sd8589934592;
    end

    p = ((d1 * sens) / 2097152 - off) / 32768;

    if (temp < ptc_pkg::TEMP_MIN) temp = longint'(ptc_pkg::TEMP_MIN);
    if (temp > ptc_pkg::TEMP_MAX) temp = longint'(ptc_pkg::TEMP_MAX);
    if (p < ptc_pkg::PRES_MIN) p = ptc_pkg::PRES_MIN;
    if (p > ptc_pkg::PRES_MAX) p = ptc_pkg::PRES_MAX;
    res.temperature = temp[ptc_pkg::TEMP_W-1:0];
    res.pressure    = p[ptc_pkg::PRES_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    comp_result_t want;
    if (!rst_n) begin
      cal_words <= '0;
      predicted_results.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ptc_pkg::REG_PRESSURE_SENSITIVITY:
            cal_words.pressure_sensitivity <= cfg_wdata;
          ptc_pkg::REG_PRESSURE_OFFSET:
            cal_words.pressure_offset <= cfg_wdata;
          ptc_pkg::REG_SENS_TEMP_COEFF:
            cal_words.sens_temp_coeff <= cfg_wdata;
          ptc_pkg::REG_OFFSET_TEMP_COEFF:
            cal_words.offset_temp_coeff <= cfg_wdata;
          ptc_pkg::REG_REFERENCE_TEMPERATURE:
            cal_words.reference_temperature <= cfg_wdata;
          ptc_pkg::REG_TEMPERATURE_COEFF:
            cal_words.temperature_coeff <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result with no reading pair outstanding (T=%0d P=%0d)",
                                    out_mon.temperature, out_mon.pressure));
        end else begin
          want = predicted_results.pop_front();
          if (out_mon.temperature !== want.temperature)
            report_mismatch($sformatf("temperature %0d, predicted %0d",
                                      out_mon.temperature, want.temperature));
          if (out_mon.pressure !== want.pressure)
            report_mismatch($sformatf("pressure %0d, predicted %0d",
                                      out_mon.pressure, want.pressure));
        end
      end
      if (in_mon.valid && in_mon.ready)
        predicted_results.push_back(compensate(in_mon.raw_pressure, in_mon.raw_temperature,
                                               cal_words));
      pending <= predicted_results.size();
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_pressure_temp_compensation.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_pressure_temp_compensation
// Stimulus and verdict for the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
// Runs on the reset calibration, then loads further sets of calibration words
// (typical factory, all ones, hot, all zeros, random) while the block is
// idle, then sends reading pairs: a directed set around the second-order and
// very-low-temperature thresholds and the field extremes, then random pairs
// mostly near the reference temperature. Both channels stall in random
// bursts until the final phase. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_pressure_temp_compensation;

  localparam logic [ptc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ptc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int                            NUM_PHASES   = 6;
  localparam int                            PHASE_PAIRS  = 64;
  localparam int                            TAIL_CYCLES  = 24;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ptc_pkg::CAL_W-1:0]     cfg_wdata;
  logic                          sink_ready = 1'b0;
  int                            stall_left;
  int                            fail_count;
  int                            pending;
  bit                            src_idle_en = 1'b1;
  bit                            sink_idle_en = 1'b1;
  ptc_pkg::ptc_cal_t             cal_now;

  ptc_in_if  in_chan();
  ptc_out_if out_chan();

  assign out_chan.ready = sink_ready;

  pressure_temp_compensation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ptc_compensation_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      sink_ready <= 1'b0;
      stall_left <= int'($urandom_range(0, 10));
    end else begin
      sink_ready <= 1'b1;
    end
  end

  task automatic load_cal(input ptc_pkg::ptc_cal_t c);
    cfg_we    <= 1'b1;
    cfg_index <= ptc_pkg::REG_PRESSURE_SENSITIVITY;
    cfg_wdata <= c.pressure_sensitivity;
    @(posedge clk);
    cfg_index <= ptc_pkg::REG_PRESSURE_OFFSET;
    cfg_wdata <= c.pressure_offset;
    @(posedge clk);
    cfg_index <= ptc_pkg::REG_SENS_TEMP_COEFF;
    cfg_wdata <= c.sens_temp_coeff;
    @(posedge clk);
    cfg_index <= ptc_pkg::REG_OFFSET_TEMP_COEFF;
    cfg_wdata <= c.offset_temp_coeff;
    @(posedge clk);
    cfg_index <= ptc_pkg::REG_REFERENCE_TEMPERATURE;
    cfg_wdata <= c.reference_temperature;
    @(posedge clk);
    cfg_index <= ptc_pkg::REG_TEMPERATURE_COEFF;
    cfg_wdata <= c.temperature_coeff;
    @(posedge clk);
    // unmapped indexes must leave the calibration untouched
    cfg_index <= REG_SPARE_LO;
    cfg_wdata <= ptc_pkg::CAL_W'($urandom);
    @(posedge clk);
    cfg_index <= REG_SPARE_HI;
    cfg_wdata <= ptc_pkg::CAL_W'($urandom);
    @(posedge clk);
    cfg_we  <= 1'b0;
    cal_now = c;
  endtask

  task automatic send_pair(input logic [ptc_pkg::RAW_W-1:0] raw_p,
                           input logic [ptc_pkg::RAW_W-1:0] raw_t);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.raw_pressure    <= raw_p;
    in_chan.raw_temperature <= raw_t;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // hold off until every predicted result has been taken
  task automatic drain;
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [ptc_pkg::RAW_W-1:0] clip_raw(input longint v);
    if (v < 0) return '0;
    if (v > 64'sd16777215) return '1;
    return v[ptc_pkg::RAW_W-1:0];
  endfunction

  // raw temperature giving roughly the wanted first-order temperature
  function automatic logic [ptc_pkg::RAW_W-1:0] raw_for_temp(input longint target);
    longint scale, tref, step;
    scale = longint'(cal_now.temperature_coeff);
    tref  = longint'(cal_now.reference_temperature);
    if (target < 2000) step = -(((2000 - target) * 8388608 + scale - 1) / scale);
    else step = ((target - 2000) * 8388608) / scale;
    return clip_raw(tref * 256 + step);
  endfunction

  function automatic logic [ptc_pkg::RAW_W-1:0] raw_near_ref();
    longint tref, spread, offs;
    tref = longint'(cal_now.reference_temperature);
    case ($urandom_range(0, 2))
      0:       spread = 4096;
      1:       spread = 262144;
      default: spread = 4194304;
    endcase
    offs = longint'($urandom_range(0, 32'(2 * spread)));
    return clip_raw(tref * 256 + offs - spread);
  endfunction

  task automatic send_random;
    logic [ptc_pkg::RAW_W-1:0] raw_p;
    logic [ptc_pkg::RAW_W-1:0] raw_t;
    raw_p = ptc_pkg::RAW_W'($urandom);
    if ($urandom_range(0, 15) == 0) raw_p = $urandom_range(0, 1) ? '1 : '0;
    raw_t = ($urandom_range(0, 9) < 6) ? raw_near_ref() : ptc_pkg::RAW_W'($urandom);
    send_pair(raw_p, raw_t);
  endtask

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    ptc_pkg::ptc_cal_t c;
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_index               <= '0;
    cfg_wdata               <= '0;
    in_chan.valid           <= 1'b0;
    in_chan.raw_pressure    <= '0;
    in_chan.raw_temperature <= '0;
    cal_now = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration
    send_pair('0, '0);
    send_pair('1, '1);
    drain();

    // typical factory words, around the correction thresholds
    c.pressure_sensitivity  = 16'd46372;
    c.pressure_offset       = 16'd43981;
    c.sens_temp_coeff       = 16'd29059;
    c.offset_temp_coeff     = 16'd27842;
    c.reference_temperature = 16'd31553;
    c.temperature_coeff     = 16'd28165;
    load_cal(c);
    send_pair(ptc_pkg::RAW_W'($urandom), {cal_now.reference_temperature, 8'h00});
    send_pair(ptc_pkg::RAW_W'($urandom), {cal_now.reference_temperature, 8'h00} - 24'd1);
    send_pair(ptc_pkg::RAW_W'($urandom), raw_for_temp(1999));
    send_pair(ptc_pkg::RAW_W'($urandom), raw_for_temp(1990));
    send_pair(ptc_pkg::RAW_W'($urandom), raw_for_temp(-1500));
    send_pair(ptc_pkg::RAW_W'($urandom), raw_for_temp(-1501));
    send_pair('1, raw_for_temp(-4000));
    send_pair('0, raw_for_temp(-4000));
    send_pair(ptc_pkg::RAW_W'($urandom), raw_for_temp(8500));
    drain();

    c = '1;
    load_cal(c);
    send_pair('0, '0);
    send_pair('1, '0);
    send_pair('0, '1);
    send_pair('1, '1);
    drain();

    // hot: zero reference, steepest coefficient
    c.reference_temperature = '0;
    load_cal(c);
    send_pair('1, '1);
    send_pair('0, '1);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: c = '1;
        1: c = '0;
        default: begin
          c.pressure_sensitivity  = ptc_pkg::CAL_W'($urandom_range(0, 65535));
          c.pressure_offset       = ptc_pkg::CAL_W'($urandom_range(0, 65535));
          c.sens_temp_coeff       = ptc_pkg::CAL_W'($urandom_range(0, 65535));
          c.offset_temp_coeff     = ptc_pkg::CAL_W'($urandom_range(0, 65535));
          c.reference_temperature = ptc_pkg::CAL_W'($urandom_range(0, 65535));
          c.temperature_coeff     = ptc_pkg::CAL_W'($urandom_range(1, 65535));
        end
      endcase
      load_cal(c);
      if (ph == NUM_PHASES - 1) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      for (int n = 0; n < PHASE_PAIRS; n++) begin
        if (ph == 2 && n == PHASE_PAIRS / 2) drain();
        send_random();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
design/ptc_pkg.sv
design/ptc_if.sv
design/ptc_front.sv
design/ptc_queue.sv
design/ptc_back.sv
design/pressure_temp_compensation.sv
tb/sv/ptc_compensation_checker.sv
tb/sv/tb_pressure_temp_compensation.sv
